// ===== sv/cpc_pkg.sv =====
// shared constants, tables and types for the cartesian/polar converter
package cpc_pkg;

  localparam int COORD_WIDTH_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TABLE_LEN        = 24;

  // datapath: coordinates carry guard fraction bits plus headroom for cordic growth
  localparam int GUARD_BITS = 8;
  localparam int HEADROOM   = 3;

  // angle accumulator in units of 2^-20 degree
  localparam int ANG_FRAC = 20;
  localparam int ZW       = 30;
  localparam int ANGLE_W  = 16;
  localparam int ANGLE_LIMIT = 23040;

  localparam logic signed [ZW-1:0] DEG90  = ZW'(90 * (1 << ANG_FRAC));
  localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * (1 << ANG_FRAC));
  localparam logic signed [ZW-1:0] DEG360 = ZW'(360 * (1 << ANG_FRAC));

  // gain compensation K = GAIN_K / 2^30, applied to values with GUARD_BITS fraction
  localparam int GAIN_W = 30;
  localparam logic [GAIN_W-1:0] GAIN_K = GAIN_W'(652032874);
  localparam int GAIN_SHIFT = 30 + GUARD_BITS;

  // atan(2^-i) in 2^-20 degree
  localparam int ATAN_TABLE [TABLE_LEN] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  typedef struct packed {
    logic mode;    // 0 vectoring (to polar), 1 rotation (to cartesian)
    logic origin;  // vectoring input was (0,0)
  } ctrl_t;

endpackage

// ===== sv/cartesian_polar_converter.sv =====
// top level: cordic cartesian/polar converter pipeline
// path: input register, the cordic step stages, the gain stages, then the output register
// throughput: one item per cycle; each cordic step is its own register stage
// stalls: every stage holds its item and valid bit; empty stages still fill while
//   the output is stalled, so input stalls only when the whole pipeline is full
// reset: synchronous, clears the valid bits only
module cartesian_polar_converter #(
  parameter int COORD_WIDTH  = cpc_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = cpc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_mode,
  input  logic signed [COORD_WIDTH-1:0]       in_x_coord,
  input  logic signed [COORD_WIDTH-1:0]       in_y_coord,
  input  logic        [COORD_WIDTH-2:0]       in_radius_in,
  input  logic signed [cpc_pkg::ANGLE_W-1:0]  in_angle_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [COORD_WIDTH-1:0]       out_radius_out,
  output logic signed [cpc_pkg::ANGLE_W-1:0]  out_angle_out,
  output logic signed [COORD_WIDTH-1:0]       out_x_out,
  output logic signed [COORD_WIDTH-1:0]       out_y_out
);

  localparam int DW   = COORD_WIDTH + cpc_pkg::GUARD_BITS + cpc_pkg::HEADROOM;
  localparam int ZW   = cpc_pkg::ZW;
  localparam int N    = CORDIC_STEPS;
  localparam int S    = N + 4;
  localparam int MAGW = DW + cpc_pkg::GAIN_W - cpc_pkg::GAIN_SHIFT + 1;

  logic [S-1:0] vld, en;

  logic signed [DW-1:0] sx [N+1];
  logic signed [DW-1:0] sy [N+1];
  logic signed [ZW-1:0] sz [N+1];
  cpc_pkg::ctrl_t       sc [N+1];

  logic [MAGW-1:0]                   xmag, ymag;
  logic                              xneg, yneg;
  logic signed [cpc_pkg::ANGLE_W-1:0] gang;
  cpc_pkg::ctrl_t                    gctrl;

  // a stage loads when it is empty or its item moves on this cycle
  assign en[S-1] = !vld[S-1] || !out_stall;
  for (genvar k = 0; k < S - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end
  assign in_stall = !en[0];

  cpc_pre #(.COORD_WIDTH(COORD_WIDTH)) u_pre (
    .clk      (clk),
    .rst_n    (rst_n),
    .en_i     (en[0]),
    .valid_i  (in_valid),
    .mode_i   (in_mode),
    .x_i      (in_x_coord),
    .y_i      (in_y_coord),
    .radius_i (in_radius_in),
    .angle_i  (in_angle_in),
    .valid_o  (vld[0]),
    .x_o      (sx[0]),
    .y_o      (sy[0]),
    .z_o      (sz[0]),
    .ctrl_o   (sc[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_step
    cpc_stage #(.COORD_WIDTH(COORD_WIDTH), .STEP(i)) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en_i    (en[i+1]),
      .valid_i (vld[i]),
      .x_i     (sx[i]),
      .y_i     (sy[i]),
      .z_i     (sz[i]),
      .ctrl_i  (sc[i]),
      .valid_o (vld[i+1]),
      .x_o     (sx[i+1]),
      .y_o     (sy[i+1]),
      .z_o     (sz[i+1]),
      .ctrl_o  (sc[i+1])
    );
  end

  cpc_gain #(.COORD_WIDTH(COORD_WIDTH)) u_gain (
    .clk     (clk),
    .rst_n   (rst_n),
    .en_i    (en[N+2:N+1]),
    .valid_i (vld[N]),
    .x_i     (sx[N]),
    .y_i     (sy[N]),
    .z_i     (sz[N]),
    .ctrl_i  (sc[N]),
    .valid_o (vld[N+2:N+1]),
    .xmag_o  (xmag),
    .xneg_o  (xneg),
    .ymag_o  (ymag),
    .yneg_o  (yneg),
    .ang_o   (gang),
    .ctrl_o  (gctrl)
  );

  cpc_out #(.COORD_WIDTH(COORD_WIDTH)) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .en_i     (en[N+3]),
    .valid_i  (vld[N+2]),
    .xmag_i   (xmag),
    .xneg_i   (xneg),
    .ymag_i   (ymag),
    .yneg_i   (yneg),
    .ang_i    (gang),
    .ctrl_i   (gctrl),
    .valid_o  (vld[N+3]),
    .radius_o (out_radius_out),
    .angle_o  (out_angle_out),
    .x_o      (out_x_out),
    .y_o      (out_y_out)
  );

  assign out_valid = vld[S-1];

  // input backpressure only arises from a full pipeline behind a stalled output
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && (&vld)))
    else $error("input stalled while pipeline has room");

endmodule

// ===== sv/cpc_pre.sv =====
// input stage: quadrant pre-rotation and angle wrap before the cordic stages
module cpc_pre #(
  parameter int COORD_WIDTH = cpc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     en_i,
  input  logic                                     valid_i,
  input  logic                                     mode_i,
  input  logic signed [COORD_WIDTH-1:0]            x_i,
  input  logic signed [COORD_WIDTH-1:0]            y_i,
  input  logic        [COORD_WIDTH-2:0]            radius_i,
  input  logic signed [cpc_pkg::ANGLE_W-1:0]       angle_i,
  output logic                                     valid_o,
  output logic signed [COORD_WIDTH+cpc_pkg::GUARD_BITS+cpc_pkg::HEADROOM-1:0] x_o,
  output logic signed [COORD_WIDTH+cpc_pkg::GUARD_BITS+cpc_pkg::HEADROOM-1:0] y_o,
  output logic signed [cpc_pkg::ZW-1:0]            z_o,
  output cpc_pkg::ctrl_t                           ctrl_o
);

  localparam int DW = COORD_WIDTH + cpc_pkg::GUARD_BITS + cpc_pkg::HEADROOM;
  localparam int ZW = cpc_pkg::ZW;

  logic                  v_r;
  logic signed [DW-1:0]  x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0]  z_r, z_nxt;
  cpc_pkg::ctrl_t        ctrl_r, ctrl_nxt;

  logic signed [COORD_WIDTH:0] xe, ye, re, xs, ys;
  logic signed [ZW-1:0]        zv, zw;

  always_comb begin
    xe = (COORD_WIDTH+1)'(x_i);
    ye = (COORD_WIDTH+1)'(y_i);
    re = signed'({2'b00, radius_i});

    // vectoring: left half plane is turned by 180 degrees first
    xs = xe;
    ys = ye;
    zv = '0;
    if (xe[COORD_WIDTH]) begin
      xs = -xe;
      ys = -ye;
      zv = ye[COORD_WIDTH] ? -cpc_pkg::DEG180 : cpc_pkg::DEG180;
    end

    // rotation: wrap once into +-180, then fold beyond +-90 with negated radius
    zw = ZW'(angle_i) <<< (cpc_pkg::ANG_FRAC - 7);
    if (zw > cpc_pkg::DEG180) begin
      zw = zw - cpc_pkg::DEG360;
    end else if (zw < -cpc_pkg::DEG180) begin
      zw = zw + cpc_pkg::DEG360;
    end
    if (zw > cpc_pkg::DEG90) begin
      zw = zw - cpc_pkg::DEG180;
      re = -re;
    end else if (zw < -cpc_pkg::DEG90) begin
      zw = zw + cpc_pkg::DEG180;
      re = -re;
    end

    if (mode_i) begin
      x_nxt = DW'(re) <<< cpc_pkg::GUARD_BITS;
      y_nxt = '0;
      z_nxt = zw;
    end else begin
      x_nxt = DW'(xs) <<< cpc_pkg::GUARD_BITS;
      y_nxt = DW'(ys) <<< cpc_pkg::GUARD_BITS;
      z_nxt = zv;
    end
    ctrl_nxt.mode   = mode_i;
    ctrl_nxt.origin = !mode_i && (x_i == '0) && (y_i == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en_i) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      ctrl_r <= ctrl_nxt;
    end
  end

  assign valid_o = v_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign ctrl_o  = ctrl_r;

  // rotation angle must be folded into the cordic convergence range
  a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && ctrl_r.mode) |-> (z_r <= cpc_pkg::DEG90 && z_r >= -cpc_pkg::DEG90))
    else $error("rotation angle left +-90 degrees after folding");

endmodule

// ===== sv/cpc_stage.sv =====
// one cordic micro-rotation stage
module cpc_stage #(
  parameter int COORD_WIDTH = cpc_pkg::COORD_WIDTH_DEF,
  parameter int STEP        = 0
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     en_i,
  input  logic                                     valid_i,
  input  logic signed [COORD_WIDTH+cpc_pkg::GUARD_BITS+cpc_pkg::HEADROOM-1:0] x_i,
  input  logic signed [COORD_WIDTH+cpc_pkg::GUARD_BITS+cpc_pkg::HEADROOM-1:0] y_i,
  input  logic signed [cpc_pkg::ZW-1:0]            z_i,
  input  cpc_pkg::ctrl_t                           ctrl_i,
  output logic                                     valid_o,
  output logic signed [COORD_WIDTH+cpc_pkg::GUARD_BITS+cpc_pkg::HEADROOM-1:0] x_o,
  output logic signed [COORD_WIDTH+cpc_pkg::GUARD_BITS+cpc_pkg::HEADROOM-1:0] y_o,
  output logic signed [cpc_pkg::ZW-1:0]            z_o,
  output cpc_pkg::ctrl_t                           ctrl_o
);

  localparam int DW = COORD_WIDTH + cpc_pkg::GUARD_BITS + cpc_pkg::HEADROOM;
  localparam int ZW = cpc_pkg::ZW;
  localparam logic signed [ZW-1:0] ATAN = ZW'(cpc_pkg::ATAN_TABLE[STEP]);

  logic                 v_r;
  logic signed [DW-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [ZW-1:0] z_r, z_nxt;
  cpc_pkg::ctrl_t       ctrl_r;
  logic                 up;

  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    // vectoring drives y to zero, rotation drives z to zero
    up = ctrl_i.mode ? z_i[ZW-1] : !y_i[DW-1];
    if (up) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en_i) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      ctrl_r <= ctrl_i;
    end
  end

  assign valid_o = v_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign ctrl_o  = ctrl_r;

endmodule

// ===== sv/cpc_gain.sv =====
// gain compensation for both lanes over two stages, plus angle rounding
module cpc_gain #(
  parameter int COORD_WIDTH = cpc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic [1:0]                               en_i,
  input  logic                                     valid_i,
  input  logic signed [COORD_WIDTH+cpc_pkg::GUARD_BITS+cpc_pkg::HEADROOM-1:0] x_i,
  input  logic signed [COORD_WIDTH+cpc_pkg::GUARD_BITS+cpc_pkg::HEADROOM-1:0] y_i,
  input  logic signed [cpc_pkg::ZW-1:0]            z_i,
  input  cpc_pkg::ctrl_t                           ctrl_i,
  output logic [1:0]                               valid_o,
  output logic [COORD_WIDTH+cpc_pkg::GUARD_BITS+cpc_pkg::HEADROOM+cpc_pkg::GAIN_W-cpc_pkg::GAIN_SHIFT:0]
                                                   xmag_o,
  output logic                                     xneg_o,
  output logic [COORD_WIDTH+cpc_pkg::GUARD_BITS+cpc_pkg::HEADROOM+cpc_pkg::GAIN_W-cpc_pkg::GAIN_SHIFT:0]
                                                   ymag_o,
  output logic                                     yneg_o,
  output logic signed [cpc_pkg::ANGLE_W-1:0]       ang_o,
  output cpc_pkg::ctrl_t                           ctrl_o
);

  localparam int DW   = COORD_WIDTH + cpc_pkg::GUARD_BITS + cpc_pkg::HEADROOM;
  localparam int ZW   = cpc_pkg::ZW;
  localparam int AW   = cpc_pkg::ANGLE_W;
  localparam int KW   = cpc_pkg::GAIN_W;
  localparam int HALF = (DW + 1) / 2;
  localparam int HIW  = DW - HALF;
  localparam int PLW  = HALF + KW;
  localparam int PHW  = HIW + KW;
  localparam int SW   = DW + KW + 1;
  localparam int MAGW = SW - cpc_pkg::GAIN_SHIFT;
  localparam logic [SW-1:0] ROUND = SW'(1) << (cpc_pkg::GAIN_SHIFT - 1);
  localparam logic signed [ZW-1:0] ANG_HALF = ZW'(1) <<< (cpc_pkg::ANG_FRAC - 8);
  localparam logic signed [ZW-1:0] ALIM = ZW'(cpc_pkg::ANGLE_LIMIT);

  logic signed [DW-1:0] v [2];
  logic [DW-1:0]        m [2];
  logic [PLW-1:0]       pplo_r [2], pplo_nxt [2];
  logic [PHW-1:0]       pphi_r [2], pphi_nxt [2];
  logic [1:0]           neg_r, neg_nxt, neg2_r;
  logic [SW-1:0]        sum [2];
  logic [MAGW-1:0]      mag_r [2], mag_nxt [2];
  logic                 v1_r, v2_r;
  logic signed [ZW-1:0] zr, zs;
  logic signed [AW-1:0] ang1_r, ang2_r, ang_nxt;
  cpc_pkg::ctrl_t       ctrl1_r, ctrl2_r;

  assign v[0] = x_i;
  assign v[1] = y_i;

  // stage 1: magnitude split into halves, one partial product each
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      neg_nxt[k]  = v[k][DW-1];
      m[k]        = v[k][DW-1] ? DW'(-v[k]) : DW'(v[k]);
      pplo_nxt[k] = PLW'(m[k][HALF-1:0]) * PLW'(cpc_pkg::GAIN_K);
      pphi_nxt[k] = PHW'(m[k][DW-1:HALF]) * PHW'(cpc_pkg::GAIN_K);
    end
    // angle to 1/128 degree, round half up, clamp to +-180
    zr = z_i + ANG_HALF;
    zs = zr >>> (cpc_pkg::ANG_FRAC - 7);
    if (zs > ALIM) begin
      ang_nxt = AW'(ALIM);
    end else if (zs < -ALIM) begin
      ang_nxt = AW'(-ALIM);
    end else begin
      ang_nxt = AW'(zs);
    end
  end

  // stage 2: recombine partial products and round half up
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      sum[k]     = (SW'(pphi_r[k]) << HALF) + SW'(pplo_r[k]) + ROUND;
      mag_nxt[k] = sum[k][SW-1:cpc_pkg::GAIN_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en_i[0]) begin
        v1_r <= valid_i;
      end
      if (en_i[1]) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      for (int k = 0; k < 2; k++) begin
        pplo_r[k] <= pplo_nxt[k];
        pphi_r[k] <= pphi_nxt[k];
      end
      neg_r   <= neg_nxt;
      ang1_r  <= ang_nxt;
      ctrl1_r <= ctrl_i;
    end
    if (en_i[1]) begin
      for (int k = 0; k < 2; k++) begin
        mag_r[k] <= mag_nxt[k];
      end
      neg2_r  <= neg_r;
      ang2_r  <= ang1_r;
      ctrl2_r <= ctrl1_r;
    end
  end

  assign valid_o = {v2_r, v1_r};
  assign xmag_o  = mag_r[0];
  assign ymag_o  = mag_r[1];
  assign xneg_o  = neg2_r[0];
  assign yneg_o  = neg2_r[1];
  assign ang_o   = ang2_r;
  assign ctrl_o  = ctrl2_r;

endmodule

// ===== sv/cpc_out.sv =====
// output register: saturation and per-mode field selection
module cpc_out #(
  parameter int COORD_WIDTH = cpc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     en_i,
  input  logic                                     valid_i,
  input  logic [COORD_WIDTH+cpc_pkg::GUARD_BITS+cpc_pkg::HEADROOM+cpc_pkg::GAIN_W-cpc_pkg::GAIN_SHIFT:0]
                                                   xmag_i,
  input  logic                                     xneg_i,
  input  logic [COORD_WIDTH+cpc_pkg::GUARD_BITS+cpc_pkg::HEADROOM+cpc_pkg::GAIN_W-cpc_pkg::GAIN_SHIFT:0]
                                                   ymag_i,
  input  logic                                     yneg_i,
  input  logic signed [cpc_pkg::ANGLE_W-1:0]       ang_i,
  input  cpc_pkg::ctrl_t                           ctrl_i,
  output logic                                     valid_o,
  output logic        [COORD_WIDTH-1:0]            radius_o,
  output logic signed [cpc_pkg::ANGLE_W-1:0]       angle_o,
  output logic signed [COORD_WIDTH-1:0]            x_o,
  output logic signed [COORD_WIDTH-1:0]            y_o
);

  localparam int W    = COORD_WIDTH;
  localparam int AW   = cpc_pkg::ANGLE_W;
  localparam int MAGW = W + cpc_pkg::GUARD_BITS + cpc_pkg::HEADROOM + cpc_pkg::GAIN_W
                        - cpc_pkg::GAIN_SHIFT + 1;
  localparam logic [MAGW-1:0] CLIM = {{(MAGW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [AW-1:0] ALIM = AW'(cpc_pkg::ANGLE_LIMIT);
  localparam logic signed [W-1:0]  CMIN = {1'b1, {(W-1){1'b0}}};

  logic                 v_r;
  logic [W-1:0]         rad_r, rad_nxt, rsat, xsat, ysat;
  logic signed [AW-1:0] ang_r, ang_nxt;
  logic signed [W-1:0]  x_r, y_r, x_nxt, y_nxt;

  always_comb begin
    rsat = (|xmag_i[MAGW-1:W]) ? {W{1'b1}} : xmag_i[W-1:0];
    xsat = (xmag_i > CLIM) ? CLIM[W-1:0] : xmag_i[W-1:0];
    ysat = (ymag_i > CLIM) ? CLIM[W-1:0] : ymag_i[W-1:0];
    rad_nxt = '0;
    ang_nxt = '0;
    x_nxt   = '0;
    y_nxt   = '0;
    if (ctrl_i.mode) begin
      x_nxt = xneg_i ? -signed'(xsat) : signed'(xsat);
      y_nxt = yneg_i ? -signed'(ysat) : signed'(ysat);
    end else if (!ctrl_i.origin) begin
      rad_nxt = xneg_i ? '0 : rsat;
      ang_nxt = ang_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en_i) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      rad_r <= rad_nxt;
      ang_r <= ang_nxt;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
    end
  end

  assign valid_o  = v_r;
  assign radius_o = rad_r;
  assign angle_o  = ang_r;
  assign x_o      = x_r;
  assign y_o      = y_r;

  // only one mode's pair of fields can be nonzero
  a_mode_fields: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> ((x_r == '0 && y_r == '0) || (rad_r == '0 && ang_r == '0)))
    else $error("polar and cartesian outputs both nonzero");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> (ang_r <= ALIM && ang_r >= -ALIM))
    else $error("angle output outside +-180 degrees");

  // symmetric saturation never yields the most negative code
  a_coord_sym: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> (x_r != CMIN && y_r != CMIN))
    else $error("coordinate output at most negative code");

endmodule
